// ===== rtl/dual_accel_check_average_resample_defines.svh =====
// Assertion macros shared by the RTL files
`ifndef DUAL_ACCEL_CHECK_AVERAGE_RESAMPLE_DEFINES_SVH
`define DUAL_ACCEL_CHECK_AVERAGE_RESAMPLE_DEFINES_SVH

// Property must hold on every clock edge outside reset.
`define DACR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked also while reset is held.
`define DACR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dacr_pkg.sv =====
// ----------------------------------------------------------------------------
// dacr_pkg
// Shared types and constants for the dual accelerometer resampler.
// ----------------------------------------------------------------------------
`default_nettype none
package dacr_pkg;

  localparam int unsigned DEPTH_DEF    = 32;
  localparam int unsigned MAX_FILL_DEF = 16;

  localparam logic [2:0] ST_EMIT     = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_MAGN     = 3'd2;
  localparam logic [2:0] ST_FIRST    = 3'd3;
  localparam logic [2:0] ST_NOSLOT   = 3'd4;

  localparam logic [1:0] REG_DIFF   = 2'd0;
  localparam logic [1:0] REG_MAGN   = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for request
    S_CHECK,  // average and limit checks registered
    S_RDNEW,  // read newest entry
    S_SUMRD,  // walk stored entries, accumulate
    S_DIVST,  // start mean division
    S_DIVW,   // wait mean division
    S_GRID,   // compute grid, check slot
    S_INTST,  // start interpolation division
    S_INTW,   // wait interpolation division
    S_PUSH,   // write sample, present result
    S_OUT     // wait for result to leave
  } state_t;

  typedef struct packed {
    logic load;      // capture input request
    logic rd_newest; // issue read of newest entry
    logic sum_clr;
    logic sum_rd;    // issue read of entry k
    logic sum_acc;   // add read data of previous read
    logic div_mean;  // start three mean divisions
    logic grid_init;
    logic int_start; // start interpolation divisions
    logic push_first;
    logic push_cur;
    logic res_load;
    logic [2:0] res_status;
    logic res_final;
    logic res_trunc;
  } cmd_t;

  typedef struct packed {
    logic mismatch;
    logic magn;
    logic empty;
    logic sum_done;
    logic div_done;
    logic no_slot;
    logic more_slots; // grid <= stamp after advance
    logic fill_last;  // this emission reaches MAX_FILL
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/dacr_if.sv =====
// ----------------------------------------------------------------------------
// dacr_in_if / dacr_out_if / dacr_cfg_if
// Valid/ready channels of the resampler.
// ----------------------------------------------------------------------------
`default_nettype none
interface dacr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_x, first_y, first_z;
  logic signed [15:0] second_x, second_y, second_z;
  logic        [31:0] stamp;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, stamp, input ready);
  modport sink   (input valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, stamp, output ready);
endinterface

interface dacr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x, out_y, out_z;
  logic        [31:0] out_stamp;
  logic         [2:0] status;
  logic               final_res;
  logic               gap_truncated;
  modport source (output valid, out_x, out_y, out_z, out_stamp, status,
                  final_res, gap_truncated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_stamp, status,
                  final_res, gap_truncated, output ready);
endinterface

interface dacr_cfg_if;
  logic        valid;
  logic        ready;
  logic  [1:0] index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dual_accel_check_average_resample.sv =====
// ----------------------------------------------------------------------------
// dual_accel_check_average_resample
// Dual accelerometer check, average and grid resampler.
// ----------------------------------------------------------------------------
// One request at a time; a new request is taken only while idle. A request is
// checked (sensor mismatch, magnitude) as it is taken and the results are
// registered; a reject, a first sample or a missing grid slot gives one result.
// Otherwise the stored entries are summed through the ring's single registered
// read port, the mean comes from a serial division, and each emitted sample
// takes a grid step that registers the product, the division start, the serial
// division and the push (three axes in parallel). A request emits at most
// MAX_FILL samples. Results wait in one output register and a stalled receiver
// holds the sequencer. The ring needs no clearing pass: entries are only read
// after being written.
`default_nettype none
module dual_accel_check_average_resample import dacr_pkg::*; #(
  parameter int unsigned DEPTH    = DEPTH_DEF,
  parameter int unsigned MAX_FILL = MAX_FILL_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  dacr_in_if.sink    in_ch,
  dacr_out_if.source out_ch,
  dacr_cfg_if.sink   cfg_ch
);
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // controller drives ready; the datapath only reads payload
  assign in_ch.ready = in_ready;

  dacr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ready),
    .out_busy(out_ch.valid && !out_ch.ready), .sts(sts), .cmd(cmd)
  );

  dacr_datapath #(.DEPTH(DEPTH), .MAX_FILL(MAX_FILL)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );
endmodule
`default_nettype wire

// ===== rtl/dacr_div.sv =====
// ----------------------------------------------------------------------------
// dacr_div
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module dacr_div import dacr_pkg::*; #(
  parameter int unsigned NW = 56,
  parameter int unsigned DW = 33
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic        [DW-1:0] den,   // positive, nonzero
  output logic                      done,
  output logic signed [NW-1:0]      quo
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic          neg_r, busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   trial;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[NW-1] ? NW'(-num) : num;
      neg_r <= num[NW-1];
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!trial[DW]) begin
        rem_r <= trial;
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DW-1:0], q_r[NW-1]};
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

  assign done = !busy_r && !start;
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule
`default_nettype wire

// ===== rtl/dacr_datapath.sv =====
// ----------------------------------------------------------------------------
// dacr_datapath
// Input checks, sample ring, mean accumulation, grid and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_accel_check_average_resample_defines.svh"
module dacr_datapath import dacr_pkg::*; #(
  parameter int unsigned DEPTH    = DEPTH_DEF,
  parameter int unsigned MAX_FILL = MAX_FILL_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  output sts_t      sts,
  dacr_in_if.sink   in_ch,
  dacr_out_if.source out_ch,
  dacr_cfg_if.sink  cfg_ch
);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned NW = $clog2(MAX_FILL + 1);
  localparam int unsigned SW = 17 + FW + 1;

  // configuration
  logic [15:0] diff_limit_r, max_mag_r;
  logic [19:0] period_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_limit_r <= 16'd4096;
      max_mag_r    <= 16'd32767;
      period_r     <= 20'd10000;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DIFF:   diff_limit_r <= cfg_ch.data[15:0];
        REG_MAGN:   max_mag_r    <= cfg_ch.data[15:0];
        REG_PERIOD: period_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;
  logic [19:0] period;
  assign period = (period_r == '0) ? 20'd1 : period_r;

  // input capture, checks
  logic signed [15:0] avg_r [3];
  logic        [31:0] stamp_r;
  logic mism_r, magn_r;
  logic signed [16:0] d [3], s [3], av [3];
  logic        [16:0] ad [3], aa [3];
  logic mism_c, magn_c;
  always_comb begin
    mism_c = 1'b0;
    magn_c = 1'b0;
    d[0] = 17'(in_ch.first_x) - 17'(in_ch.second_x);
    d[1] = 17'(in_ch.first_y) - 17'(in_ch.second_y);
    d[2] = 17'(in_ch.first_z) - 17'(in_ch.second_z);
    s[0] = 17'(in_ch.first_x) + 17'(in_ch.second_x);
    s[1] = 17'(in_ch.first_y) + 17'(in_ch.second_y);
    s[2] = 17'(in_ch.first_z) + 17'(in_ch.second_z);
    for (int a = 0; a < 3; a++) begin
      ad[a] = d[a][16] ? 17'(-d[a]) : d[a];
      if (ad[a] > {1'b0, diff_limit_r}) mism_c = 1'b1;
      av[a] = s[a] >>> 1;  // floor
      aa[a] = av[a][16] ? 17'(-av[a]) : av[a];
      if (aa[a] > {1'b0, max_mag_r}) magn_c = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < 3; a++) avg_r[a] <= av[a][15:0];
      stamp_r <= in_ch.stamp;
      mism_r  <= mism_c;
      magn_r  <= magn_c && !mism_c;
    end
  end

  // ring, one write and one registered read port
  logic [79:0] ring [DEPTH];
  logic [FW-1:0] fill_r;
  logic [IW-1:0] newest_r;
  logic [IW-1:0] rd_addr;
  logic [79:0]   rd_q;
  logic [FW-1:0] k_r;
  logic          acc_pend_r;
  logic [IW-1:0] wr_idx;
  logic [79:0]   wr_data;
  logic          wr_en;
  logic signed [15:0] cur [3];
  logic [31:0] grid_r;

  // i - k around the ring; i < DEPTH and k <= DEPTH, so one wrap at most
  function automatic logic [IW-1:0] wrap_sub(input logic [IW-1:0] i, input logic [FW-1:0] k);
    logic [IW+FW:0] t;
    t = {1'b0, {FW{1'b0}}, i} + (IW+FW+1)'(DEPTH) - (IW+FW+1)'(k);
    if (t >= (IW+FW+1)'(DEPTH)) t = t - (IW+FW+1)'(DEPTH);
    wrap_sub = IW'(t);
  endfunction

  always_comb begin
    rd_addr = cmd.sum_rd ? wrap_sub(newest_r, k_r) : newest_r;
    wr_en   = cmd.push_first || cmd.push_cur;
    if (fill_r == '0) wr_idx = newest_r;
    else wr_idx = wrap_sub(newest_r, FW'(DEPTH - 1));
    if (cmd.push_first) wr_data = {avg_r[0], avg_r[1], avg_r[2], stamp_r};
    else wr_data = {cur[0], cur[1], cur[2], grid_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) ring[wr_idx] <= wr_data;
    rd_q <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      newest_r <= '0;
    end else if (wr_en) begin
      newest_r <= wr_idx;
      if (fill_r != FW'(DEPTH)) fill_r <= fill_r + 1'b1;
    end
  end

  // sum over stored entries
  logic signed [SW-1:0] sum_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_pend_r <= 1'b0;
    end else begin
      acc_pend_r <= cmd.sum_rd;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      k_r <= '0;
      for (int a = 0; a < 3; a++) sum_r[a] <= SW'(avg_r[a]);
    end else begin
      if (cmd.sum_rd) k_r <= k_r + 1'b1;
      if (acc_pend_r) begin
        sum_r[0] <= sum_r[0] + SW'($signed(rd_q[79:64]));
        sum_r[1] <= sum_r[1] + SW'($signed(rd_q[63:48]));
        sum_r[2] <= sum_r[2] + SW'($signed(rd_q[47:32]));
      end
    end
  end

  // newest sample latched
  logic signed [15:0] last_r [3];
  logic        [31:0] last_ts_r;
  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      last_r[0] <= $signed(rd_q[79:64]);
      last_r[1] <= $signed(rd_q[63:48]);
      last_r[2] <= $signed(rd_q[47:32]);
      last_ts_r <= rd_q[31:0];
    end else if (cmd.push_cur) begin
      for (int a = 0; a < 3; a++) last_r[a] <= cur[a];
      last_ts_r <= grid_r;
    end
  end

  // three shared dividers, used for mean then for interpolation
  localparam int unsigned DNW = 56;
  logic signed [DNW-1:0] dnum [3];
  logic        [32:0]    dden;
  logic                  dstart;
  logic                  ddone [3];
  logic signed [DNW-1:0] dquo [3];
  logic signed [16:0]    mean_r [3];
  logic signed [17:0]    mdiff [3];
  logic signed [37:0]    prod_r [3];
  assign dstart = cmd.div_mean || cmd.int_start;
  always_comb begin
    dden = cmd.div_mean ? 33'(fill_r) + 33'd1
                        : 33'({1'b0, stamp_r}) - 33'({1'b0, last_ts_r});
    for (int a = 0; a < 3; a++) begin
      mdiff[a] = 18'(mean_r[a]) - 18'(last_r[a]);
      dnum[a]  = cmd.div_mean ? DNW'(sum_r[a]) : DNW'(prod_r[a]);
    end
  end
  // product registered ahead of the division
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) prod_r[a] <= mdiff[a] * $signed({1'b0, period});
  end
  for (genvar g = 0; g < 3; g++) begin : g_div
    dacr_div #(.NW(DNW), .DW(33)) u_div (
      .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum[g]), .den(dden),
      .done(ddone[g]), .quo(dquo[g])
    );
    assign cur[g] = 16'(dquo[g]) + last_r[g];
  end
  logic div_mean_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_mean_pend_r <= 1'b0;
    else if (cmd.div_mean) div_mean_pend_r <= 1'b1;
    else if (ddone[0] && div_mean_pend_r) div_mean_pend_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (div_mean_pend_r && ddone[0])
      for (int a = 0; a < 3; a++) mean_r[a] <= 17'(dquo[a]);
  end

  // grid
  logic [32:0] grid_nx;
  logic [32:0] grid_nx_adv;
  logic [NW-1:0] n_r;
  logic grid_ovf_r;
  assign grid_nx = 33'(last_ts_r) + 33'(period);
  assign grid_nx_adv = 33'(grid_r) + 33'(period);
  always_ff @(posedge clk) begin
    if (cmd.grid_init) begin
      grid_r     <= grid_nx[31:0];
      grid_ovf_r <= grid_nx[32];
      n_r        <= '0;
    end else if (cmd.push_cur) begin
      n_r        <= n_r + 1'b1;
      {grid_ovf_r, grid_r} <= 33'(grid_r) + 33'(period);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_ch.status        <= cmd.res_status;
      out_ch.final_res     <= cmd.res_final;
      out_ch.gap_truncated <= cmd.res_trunc;
      if (cmd.push_cur) begin
        out_ch.out_x <= cur[0]; out_ch.out_y <= cur[1]; out_ch.out_z <= cur[2];
        out_ch.out_stamp <= grid_r;
      end else if (cmd.push_first) begin
        out_ch.out_x <= avg_r[0]; out_ch.out_y <= avg_r[1];
        out_ch.out_z <= avg_r[2]; out_ch.out_stamp <= stamp_r;
      end else if (fill_r == '0) begin
        out_ch.out_x <= '0; out_ch.out_y <= '0; out_ch.out_z <= '0;
        out_ch.out_stamp <= '0;
      end else begin
        out_ch.out_x <= $signed(rd_q[79:64]); out_ch.out_y <= $signed(rd_q[63:48]);
        out_ch.out_z <= $signed(rd_q[47:32]); out_ch.out_stamp <= rd_q[31:0];
      end
    end
  end

  assign sts.mismatch   = mism_r;
  assign sts.magn       = magn_r;
  assign sts.empty      = (fill_r == '0);
  assign sts.sum_done   = (k_r == fill_r);
  assign sts.div_done   = ddone[0] && !div_mean_pend_r;
  assign sts.no_slot    = grid_ovf_r || (grid_r > stamp_r);
  assign sts.more_slots = !(grid_nx_adv[32] || grid_nx_adv[31:0] > stamp_r);
  assign sts.fill_last  = (n_r == NW'(MAX_FILL - 1));

  `DACR_ASSERT(a_fill_range, clk, rst_n, fill_r <= FW'(DEPTH), "fill count beyond depth")
  `DACR_ASSERT(a_push_excl, clk, rst_n, !(cmd.push_first && cmd.push_cur), "two pushes at once")
  `DACR_ASSERT(a_first_empty, clk, rst_n, cmd.push_first |-> fill_r == '0, "first push into non-empty ring")
endmodule
`default_nettype wire

// ===== rtl/dacr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dacr_ctrl
// Sequencer for check, mean, grid and interpolation steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_accel_check_average_resample_defines.svh"
module dacr_ctrl import dacr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic out_busy,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;
  logic   emit_r, emit_nxt;  // an emission is in flight (not the one-shot case)

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.rd_newest = 1'b1;
        state_nxt = S_RDNEW;
      end
      S_RDNEW: begin
        if (!out_busy) begin
          if (sts.mismatch || sts.magn) begin
            cmd.res_load = 1'b1; cmd.res_final = 1'b1;
            cmd.res_status = sts.mismatch ? ST_MISMATCH : ST_MAGN;
            state_nxt = S_OUT;
          end else if (sts.empty) begin
            cmd.push_first = 1'b1; cmd.res_load = 1'b1; cmd.res_final = 1'b1;
            cmd.res_status = ST_FIRST;
            state_nxt = S_OUT;
          end else begin
            cmd.sum_clr = 1'b1;
            state_nxt = S_SUMRD;
          end
        end
      end
      S_SUMRD: begin
        if (!sts.sum_done) cmd.sum_rd = 1'b1;
        else state_nxt = S_DIVST;
      end
      S_DIVST: begin
        // the last accumulation has landed by the time this state starts the division
        cmd.div_mean = 1'b1;
        cmd.grid_init = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) state_nxt = S_GRID;
      end
      S_GRID: begin
        // also the cycle that registers the product from the newest sample
        if (sts.no_slot) begin
          cmd.rd_newest = 1'b1;
          state_nxt = S_PUSH;
          emit_nxt = 1'b0;
        end else begin
          state_nxt = S_INTST;
          emit_nxt = 1'b1;
        end
      end
      S_INTST: begin
        cmd.int_start = 1'b1;
        state_nxt = S_INTW;
      end
      S_INTW: begin
        if (sts.div_done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!out_busy) begin
          cmd.res_load = 1'b1;
          if (!emit_r) begin
            cmd.res_status = ST_NOSLOT; cmd.res_final = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.push_cur = 1'b1;
            cmd.res_status = ST_EMIT;
            if (!sts.more_slots || sts.fill_last) begin
              cmd.res_final = 1'b1;
              cmd.res_trunc = sts.more_slots;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_GRID;
            end
          end
        end
      end
      S_OUT: begin
        emit_nxt = 1'b0;
        if (!out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `DACR_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> state_r == S_IDLE, "ready outside idle")
  `DACR_ASSERT(a_load_check, clk, rst_n, cmd.load |=> state_r == S_CHECK, "load not followed by check")
  `DACR_ASSERT(a_res_hold, clk, rst_n, cmd.res_load |-> !out_busy, "result overwrite")
endmodule
`default_nettype wire

// ===== tb/tb_dual_accel_check_average_resample.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_accel_check_average_resample
// Self-checking bench: random and directed sensor pairs against a behavioral
// predictor of the check, average and grid resample path.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_dual_accel_check_average_resample;
  import dacr_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int FILL_MAX   = MAX_FILL_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] ax1, ay1, az1, ax2, ay2, az2;
    logic [31:0] stamp;
  } request_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic [31:0] stamp;
    logic [2:0]  status;
    logic        fin;
    logic        trunc;
  } sample_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dacr_in_if  in_ch();
  dacr_out_if out_ch();
  dacr_cfg_if cfg_ch();

  dual_accel_check_average_resample u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  int          ring_x[RING_DEPTH], ring_y[RING_DEPTH], ring_z[RING_DEPTH];
  logic [31:0] ring_t[RING_DEPTH];
  int          fill_cnt;
  int          newest;
  logic [15:0] lim_diff;
  logic [15:0] lim_magn;
  logic [19:0] period_us;

  request_t    pending_reqs[$];
  sample_res_t expected_samples[$];
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          quiet_mode = 0;   // no random idling in this stretch
  bit          hold_off = 0;     // receiver long stall request

  task automatic report_mismatch(input string what);
    $display("MISMATCH: %s at %0t", what, $time);
    err_count++;
  endtask

  function automatic void queue_req(request_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void push_newest(ref sample_res_t q[$], input logic [2:0] st);
    sample_res_t r;
    if (fill_cnt == 0) begin
      r.x = '0; r.y = '0; r.z = '0; r.stamp = '0;
    end else begin
      r.x = 16'(ring_x[newest]); r.y = 16'(ring_y[newest]); r.z = 16'(ring_z[newest]);
      r.stamp = ring_t[newest];
    end
    r.status = st; r.fin = 1'b1; r.trunc = 1'b0;
    q = {q, r};
  endfunction

  function automatic void ring_store(int x, int y, int z, logic [31:0] ts);
    int idx;
    idx = (fill_cnt == 0) ? newest : (newest + 1) % RING_DEPTH;
    ring_x[idx] = x; ring_y[idx] = y; ring_z[idx] = z; ring_t[idx] = ts;
    newest = idx;
    if (fill_cnt < RING_DEPTH) fill_cnt++;
  endfunction

  // Works out the results of one accepted request and updates the store.
  function automatic void predict_resample(request_t rq);
    int p[3], q[3], avg[3], mean[3], cur[3], lastv[3];
    longint sum, diff, dt, per, grid;
    int n, d, s;
    sample_res_t r;
    p = '{rq.ax1, rq.ay1, rq.az1};
    q = '{rq.ax2, rq.ay2, rq.az2};
    for (int a = 0; a < 3; a++) begin
      d = p[a] - q[a];
      s = p[a] + q[a];
      if ((d < 0 ? -d : d) > int'(lim_diff)) begin
        push_newest(expected_samples, ST_MISMATCH);
        return;
      end
      avg[a] = (s >= 0) ? s / 2 : -((1 - s) / 2);   // floor average
    end
    for (int a = 0; a < 3; a++)
      if ((avg[a] < 0 ? -avg[a] : avg[a]) > int'(lim_magn)) begin
        push_newest(expected_samples, ST_MAGN);
        return;
      end
    if (fill_cnt == 0) begin
      ring_store(avg[0], avg[1], avg[2], rq.stamp);
      push_newest(expected_samples, ST_FIRST);
      return;
    end
    for (int a = 0; a < 3; a++) begin
      sum = avg[a];
      for (int k = 0; k < fill_cnt; k++) begin
        d = (newest + RING_DEPTH - k) % RING_DEPTH;
        sum += (a == 0) ? ring_x[d] : (a == 1) ? ring_y[d] : ring_z[d];
      end
      mean[a] = int'(sum / longint'(fill_cnt + 1));
    end
    per = (period_us == 0) ? 1 : longint'(period_us);
    grid = longint'(ring_t[newest]) + per;
    if (grid > longint'(rq.stamp)) begin
      push_newest(expected_samples, ST_NOSLOT);
      return;
    end
    n = 0;
    while (grid <= longint'(rq.stamp) && n < FILL_MAX) begin
      lastv = '{ring_x[newest], ring_y[newest], ring_z[newest]};
      dt = longint'(rq.stamp) - longint'(ring_t[newest]);
      for (int a = 0; a < 3; a++) begin
        diff = longint'(mean[a]) - lastv[a];
        cur[a] = int'((diff * per) / dt) + lastv[a];
      end
      ring_store(cur[0], cur[1], cur[2], grid[31:0]);
      r.x = 16'(cur[0]); r.y = 16'(cur[1]); r.z = 16'(cur[2]); r.stamp = grid[31:0];
      r.status = ST_EMIT; r.fin = 1'b0; r.trunc = 1'b0;
      expected_samples = {expected_samples, r};
      grid += per;
      n++;
    end
    expected_samples[$].fin = 1'b1;
    if (grid <= longint'(rq.stamp)) expected_samples[$].trunc = 1'b1;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // previous request accepted (or none offered)
      if (in_ch.valid) begin
        predict_resample(pending_reqs[0]);
        pending_reqs.delete(0);
      end
      if (pending_reqs.size() > 0 && (quiet_mode || $urandom_range(99) >= 18)) begin
        in_ch.valid    <= 1'b1;
        in_ch.first_x  <= pending_reqs[0].ax1;
        in_ch.first_y  <= pending_reqs[0].ay1;
        in_ch.first_z  <= pending_reqs[0].az1;
        in_ch.second_x <= pending_reqs[0].ax2;
        in_ch.second_y <= pending_reqs[0].ay2;
        in_ch.second_z <= pending_reqs[0].az2;
        in_ch.stamp    <= pending_reqs[0].stamp;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk) begin
    sample_res_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_samples[0];
          expected_samples.delete(0);
          if (out_ch.out_x !== e.x) report_mismatch($sformatf("out_x %0d exp %0d",
            out_ch.out_x, e.x));
          if (out_ch.out_y !== e.y) report_mismatch($sformatf("out_y %0d exp %0d",
            out_ch.out_y, e.y));
          if (out_ch.out_z !== e.z) report_mismatch($sformatf("out_z %0d exp %0d",
            out_ch.out_z, e.z));
          if (out_ch.out_stamp !== e.stamp) report_mismatch($sformatf(
            "out_stamp %0d exp %0d", out_ch.out_stamp, e.stamp));
          if (out_ch.status !== e.status) report_mismatch($sformatf(
            "status %0d exp %0d", out_ch.status, e.status));
          if (out_ch.final_res !== e.fin) report_mismatch("final_res");
          if (out_ch.gap_truncated !== e.trunc) report_mismatch("gap_truncated");
        end
      end
      out_ch.ready <= !hold_off && (quiet_mode || $urandom_range(99) >= 18);
    end
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ----------------------------------------------------------- stimulus
  function automatic request_t make_pair(int x, int y, int z, int dx, int dy,
                                         int dz, logic [31:0] ts);
    request_t r;
    r.ax1 = 16'(x); r.ay1 = 16'(y); r.az1 = 16'(z);
    r.ax2 = 16'(x + dx); r.ay2 = 16'(y + dy); r.az2 = 16'(z + dz);
    r.stamp = ts;
    return r;
  endfunction

  function automatic request_t rand_raw();
    request_t r;
    r.ax1 = 16'($urandom); r.ay1 = 16'($urandom); r.az1 = 16'($urandom);
    r.ax2 = 16'($urandom); r.ay2 = 16'($urandom); r.az2 = 16'($urandom);
    r.stamp = $urandom;
    return r;
  endfunction

  // random well-formed pair close together within 16-bit range
  function automatic request_t rand_good(logic [31:0] ts);
    request_t r;
    int b[3], o[3];
    for (int a = 0; a < 3; a++) begin
      b[a] = $urandom_range(65535) - 32768;
      o[a] = $urandom_range(200) - 100;
      if (b[a] + o[a] > 32767 || b[a] + o[a] < -32768) o[a] = -o[a];
    end
    r = make_pair(b[0], b[1], b[2], o[0], o[1], o[2], ts);
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_DIFF:   lim_diff  = val[15:0];
      REG_MAGN:   lim_magn  = val[15:0];
      REG_PERIOD: period_us = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // all issued requests done, then the block's latency before touching config
  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  initial begin
    logic [31:0] ts;
    request_t r;
    in_ch.valid = 0; in_ch.first_x = 0; in_ch.first_y = 0; in_ch.first_z = 0;
    in_ch.second_x = 0; in_ch.second_y = 0; in_ch.second_z = 0; in_ch.stamp = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_DIFF; cfg_ch.data = 0;
    fill_cnt = 0; newest = 0;
    lim_diff = 16'd4096; lim_magn = 16'd32767; period_us = 20'd10000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default limits first
    queue_req(make_pair(0, 0, 0, 5000, 0, 0, 32'd100));  // mismatch, empty
    queue_req(make_pair(32767, 0, 0, -1, 0, 0, 32'd100)); // first stored
    queue_req(make_pair(100, 100, 100, 0, 0, 0, 32'd50)); // stamp backward
    queue_req(make_pair(-200, 300, -400, 3, -3, 1, 32'd20100)); // one+ slot
    queue_req(make_pair(0, 0, 0, 4097, 0, 0, 32'd40000)); // mismatch, stored
    drain();

    // extremes of the registers
    write_reg(REG_DIFF, 20'hFFFF);
    write_reg(REG_MAGN, 20'd32768);
    write_reg(REG_PERIOD, 20'd0);   // period zero acts as one
    queue_req(make_pair(-32768, -32768, -32768, 65535, 0, 0, 32'd20105));
    queue_req(make_pair(-32768, -32768, -32768, 0, 0, 0, 32'd20200)); // trunc
    queue_req(make_pair(32767, 32767, 32767, 0, 0, 0, 32'hFFFF_FFFF));
    drain();
    write_reg(REG_MAGN, 20'd0);
    write_reg(REG_DIFF, 20'd0);
    write_reg(REG_PERIOD, 20'hFFFFF);
    queue_req(make_pair(1, 0, 0, 0, 0, 0, 32'd0));      // magnitude reject
    queue_req(make_pair(0, 0, 0, 1, 0, 0, 32'd0));      // mismatch at zero
    queue_req(make_pair(-1, 0, 0, 1, 0, 0, 32'd0));     // mismatch, diff limit is zero
    drain();

    // random phases, mostly well-formed with advancing stamps
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_DIFF, (ph % 3 == 0) ? 20'd150 : 20'($urandom_range(65535)));
      write_reg(REG_MAGN, (ph == 2) ? 20'd30000 : 20'($urandom_range(32768)));
      write_reg(REG_PERIOD, 20'($urandom_range(1, 3000)));
      quiet_mode = (ph == 1);
      ts = $urandom_range(100000);
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(9) == 0) begin
          r = rand_raw();
        end else begin
          // mostly one or two slots, sometimes a long gap
          if ($urandom_range(9) == 0) ts += $urandom_range(3000 * 20);
          else ts += $urandom_range(period_us * 2 + 1);
          r = rand_good(ts);
        end
        queue_req(r);
      end
      if (ph == 3) begin
        // receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    quiet_mode = 1'b0;
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== dual_accel_check_average_resample.f =====
+incdir+rtl
rtl/dacr_pkg.sv
rtl/dacr_if.sv
rtl/dacr_div.sv
rtl/dacr_datapath.sv
rtl/dacr_ctrl.sv
rtl/dual_accel_check_average_resample.sv
tb/tb_dual_accel_check_average_resample.sv
